/* hdl/assert_macros.svh */
// assertion macros for the checker file snm_chk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define SNM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define SNM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hdl/snm_pkg.sv */
// ----------------------------------------------------------------------------
// snm_pkg
// Shared constants, widths and helper functions of the surface nets mesher.
// ----------------------------------------------------------------------------
`default_nettype none

package snm_pkg;

    localparam int GRID_SIDE_MAX_DEF = 32;
    localparam int Q12_ONE           = 4096;
    localparam int POS_W             = 17;
    localparam int POS_MAX           = 131071;
    localparam int RAW_ADDR_W        = 15;
    localparam int RAW_ADDR_MAX      = 32767;
    localparam int IN_DATA_W         = 144;
    localparam int OUT_DATA_W        = 72;
    localparam int NUM_EDGES         = 12;

    // shared divider widths
    localparam int DIV_NUM_W = 29;
    localparam int DIV_DVS_W = 18;
    localparam int DIV_Q_W   = 13;

    // result kinds
    localparam logic KIND_VERTEX   = 1'b0;
    localparam logic KIND_TRIANGLE = 1'b1;

    // corner numbers at both ends of a cell edge, {end b, end a}
    function automatic logic [5:0] edge_ends(input logic [3:0] e);
        logic [5:0] r;
        unique case (e)
            4'd0:    r = {3'd1, 3'd0};
            4'd1:    r = {3'd3, 3'd2};
            4'd2:    r = {3'd5, 3'd4};
            4'd3:    r = {3'd7, 3'd6};
            4'd4:    r = {3'd2, 3'd0};
            4'd5:    r = {3'd3, 3'd1};
            4'd6:    r = {3'd6, 3'd4};
            4'd7:    r = {3'd7, 3'd5};
            4'd8:    r = {3'd4, 3'd0};
            4'd9:    r = {3'd5, 3'd1};
            4'd10:   r = {3'd6, 3'd2};
            4'd11:   r = {3'd7, 3'd3};
            default: r = {3'd1, 3'd0};
        endcase
        return r;
    endfunction

    // largest shift k with depth << k still inside the raw address range
    function automatic int mod_kmax(input longint d);
        int k;
        k = 0;
        for (int i = 0; i < 16; i++)
        begin
            if ((i == k) && ((d << (i + 1)) <= longint'(RAW_ADDR_MAX)))
                k = i + 1;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

/* hdl/snm_div.sv */
// ----------------------------------------------------------------------------
// snm_div
// Restoring divider, one quotient bit per cycle, quotient known below 2^13.
// ----------------------------------------------------------------------------
`default_nettype none

module snm_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [snm_pkg::DIV_NUM_W-1:0]  num,
    input  wire logic [snm_pkg::DIV_DVS_W-1:0]  dvs,
    output logic                                done,
    output logic [snm_pkg::DIV_Q_W-1:0]         quot
);

    localparam int NW = snm_pkg::DIV_NUM_W;
    localparam int QW = snm_pkg::DIV_Q_W;
    localparam int SW = snm_pkg::DIV_DVS_W + QW;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [3:0]      k_reg, k_next;
    logic [NW-1:0]   rem_reg, rem_next;
    logic [snm_pkg::DIV_DVS_W-1:0] dvs_reg, dvs_next;
    logic [QW-1:0]   quot_reg, quot_next;
    logic [SW-1:0]   shifted;
    logic            fits;

    // one compare and subtract per cycle
    always_comb
    begin
        shifted   = SW'(dvs_reg) << k_reg;
        fits      = SW'(rem_reg) >= shifted;
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = 4'(QW - 1);
            rem_next  = num;
            dvs_next  = dvs;
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_next = NW'(SW'(rem_reg) - shifted);
            quot_next[k_reg] = fits;
            if (k_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                k_next = k_reg - 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

`default_nettype wire

/* hdl/surface_nets_cell_mesher_unit.sv */
// ----------------------------------------------------------------------------
// surface_nets_cell_mesher_unit
// Naive surface nets mesher: one grid cell in, a vertex and triangle indices out.
// ----------------------------------------------------------------------------
// One cell word is taken at a time. A cell whose corners all share a sign is
// dropped in S_IDLE. Otherwise every crossing edge and each of the three
// mean coordinates goes through one shared restoring divider (13 steps),
// every edge without a crossing is skipped in S_EDGE, the map address is
// formed in S_BASE1 and S_BASE2 and then reduced step by step modulo the map
// depth in S_MOD (one step at the default size), and each axis that closes a
// quad passes S_AXIS, makes three reads of the vertex map through S_TADDR,
// S_MOD, S_TREAD and S_TCAP (registered read) and emits six output words.
// The vertex map has no reset and no clearing pass; an entry reads as
// garbage until written. Write grid_res only while no cell is in flight.
`default_nettype none

module surface_nets_cell_mesher_unit #(
    parameter int GRID_SIDE_MAX = snm_pkg::GRID_SIDE_MAX_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // config: grid_res
    input  wire logic                              cfg_we,
    input  wire logic [4:0]                        cfg_wdata,
    // cell_x, cell_y, cell_z, density_c0 .. density_c7
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [snm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // pos_x, pos_y, pos_z, vertex_index
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [snm_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // result_kind
    output logic                                   m_axis_tuser,
    // last_of_cell
    output logic                                   m_axis_tlast
);

    localparam int MAP_DEPTH = GRID_SIDE_MAX * GRID_SIDE_MAX * GRID_SIDE_MAX;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int KMAX      = snm_pkg::mod_kmax(longint'(MAP_DEPTH));
    localparam int RW        = snm_pkg::RAW_ADDR_W;
    localparam int NE        = snm_pkg::NUM_EDGES;
    localparam int PAD_W     = snm_pkg::OUT_DATA_W - 3 * snm_pkg::POS_W - 16;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EDGE  = 4'd1;
    localparam logic [3:0] S_DIVW  = 4'd2;
    localparam logic [3:0] S_AVG   = 4'd3;
    localparam logic [3:0] S_BASE1 = 4'd4;
    localparam logic [3:0] S_BASE2 = 4'd5;
    localparam logic [3:0] S_MOD   = 4'd6;
    localparam logic [3:0] S_VTX   = 4'd7;
    localparam logic [3:0] S_AXIS  = 4'd8;
    localparam logic [3:0] S_TADDR = 4'd9;
    localparam logic [3:0] S_TREAD = 4'd10;
    localparam logic [3:0] S_TCAP  = 4'd11;
    localparam logic [3:0] S_TEMIT = 4'd12;

    // control registers
    logic [3:0]  state_reg, state_next;
    logic [4:0]  grid_res_reg, grid_res_next;
    logic [15:0] vcount_reg, vcount_next;
    logic        out_valid_reg, out_valid_next;
    logic        avg_ph_reg, avg_ph_next;
    logic        tri_ph_reg, tri_ph_next;

    // payload registers
    logic [4:0]  cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [15:0] na_reg [NE], na_next [NE];
    logic [15:0] nb_reg [NE], nb_next [NE];
    logic        x_reg [NE], x_next [NE];
    logic [3:0]  e_reg, e_next;
    logic [3:0]  n_reg, n_next;
    logic [15:0] sum_reg [3], sum_next [3];
    logic [16:0] pos_reg [3], pos_next [3];
    logic [1:0]  axis_reg, axis_next;
    logic [2:0]  tri_reg, tri_next;
    logic        m1_reg, m1_next;
    logic [9:0]  tmp_reg, tmp_next;
    logic [10:0] sq_reg, sq_next;
    logic [RW-1:0] base_reg, base_next;
    logic [RW-1:0] mod_r_reg, mod_r_next;
    logic [3:0]  mod_k_reg, mod_k_next;
    logic [1:0]  j_reg, j_next;
    logic [2:0]  step_reg, step_next;
    logic [15:0] v_reg [4], v_next [4];
    logic [snm_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic        out_kind_reg, out_kind_next;
    logic        out_last_reg, out_last_next;

    // vertex map
    logic [15:0] map_mem [MAP_DEPTH];
    logic [15:0] rd_data_reg;
    logic        wr_en, rd_en;
    logic [AW-1:0] map_addr;

    // divider hookup
    logic        div_start, div_done;
    logic [snm_pkg::DIV_NUM_W-1:0] div_num;
    logic [snm_pkg::DIV_DVS_W-1:0] div_dvs;
    logic [snm_pkg::DIV_Q_W-1:0]   div_quot;

    // unpacked input word
    logic [4:0]  in_c [3];
    logic [15:0] in_d [8];
    logic [7:0]  in_mask;
    logic [15:0] in_abs [8];
    logic [5:0]  edge_tab [NE];

    // helpers
    logic        out_free;
    logic [5:0]  side;
    logic [5:0]  ends;
    logic [RW-1:0] s1, s2, sub;
    logic [RW+KMAX:0] mod_sh;
    logic [RW-1:0] mod_step;
    logic [4:0]  c_sel;
    logic [17:0] pos_sum;
    logic [2:0]  tri_rest;

    snm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .dvs   (div_dvs),
        .done  (div_done),
        .quot  (div_quot)
    );

    // input unpacking, sign mask and magnitudes
    always_comb
    begin
        for (int a = 0; a < 3; a++)
            in_c[a] = s_axis_tdata[5*a +: 5];
        for (int i = 0; i < 8; i++)
        begin
            in_d[i]    = s_axis_tdata[15 + 16*i +: 16];
            in_mask[i] = !in_d[i][15] && (in_d[i] != 16'd0);
            in_abs[i]  = in_d[i][15] ? (~in_d[i] + 16'd1) : in_d[i];
        end
    end

    // corner pairs of all edges
    always_comb
    begin
        for (int e = 0; e < NE; e++)
            edge_tab[e] = snm_pkg::edge_ends(4'(e));
    end

    assign side     = {1'b0, grid_res_reg} + 6'd1;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign ends     = snm_pkg::edge_ends(e_reg);
    assign tri_rest = tri_reg >> axis_reg >> 1;

    // neighbor strides of the current axis, swapped by the sign of corner 0
    always_comb
    begin
        unique case (axis_reg)
            2'd0:    begin s1 = RW'(side);   s2 = RW'(sq_reg); end
            2'd1:    begin s1 = RW'(sq_reg); s2 = RW'(1);      end
            default: begin s1 = RW'(1);      s2 = RW'(side);   end
        endcase
        if (m1_reg)
        begin
            sub = s1;
            s1  = s2;
            s2  = sub;
        end
        unique case (j_reg)
            2'd1:    sub = s1;
            2'd2:    sub = s2;
            default: sub = s1 + s2;
        endcase
    end

    // modulo reduction step by the map depth
    always_comb
    begin
        mod_sh   = (RW+KMAX+1)'(MAP_DEPTH) << mod_k_reg;
        mod_step = ((RW+KMAX+1)'(mod_r_reg) >= mod_sh)
                 ? RW'((RW+KMAX+1)'(mod_r_reg) - mod_sh) : mod_r_reg;
    end

    // cell coordinate of the current axis
    always_comb
    begin
        unique case (axis_reg)
            2'd0:    c_sel = cx_reg;
            2'd1:    c_sel = cy_reg;
            default: c_sel = cz_reg;
        endcase
    end

    assign pos_sum = {1'b0, c_sel, 12'd0} + 18'(div_quot);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        grid_res_next = cfg_we ? cfg_wdata : grid_res_reg;
        vcount_next   = vcount_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        avg_ph_next   = avg_ph_reg;
        tri_ph_next   = tri_ph_reg;
        cx_next = cx_reg; cy_next = cy_reg; cz_next = cz_reg;
        na_next = na_reg; nb_next = nb_reg; x_next = x_reg;
        e_next = e_reg; n_next = n_reg;
        sum_next = sum_reg; pos_next = pos_reg;
        axis_next = axis_reg; tri_next = tri_reg; m1_next = m1_reg;
        tmp_next = tmp_reg; sq_next = sq_reg; base_next = base_reg;
        mod_r_next = mod_r_reg; mod_k_next = mod_k_reg;
        j_next = j_reg; step_next = step_reg; v_next = v_reg;
        out_data_next = out_data_reg;
        out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;
        s_axis_tready = 1'b0;
        div_start = 1'b0;
        div_num   = {na_reg[0], 13'd0}
                  + snm_pkg::DIV_NUM_W'({1'b0, na_reg[0]} + {1'b0, nb_reg[0]});
        div_dvs   = {({1'b0, na_reg[0]} + {1'b0, nb_reg[0]}), 1'b0};
        wr_en = 1'b0;
        rd_en = 1'b0;
        map_addr = AW'(mod_r_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && (in_mask != 8'h00) && (in_mask != 8'hff))
                begin
                    cx_next = in_c[0]; cy_next = in_c[1]; cz_next = in_c[2];
                    for (int e = 0; e < NE; e++)
                    begin
                        na_next[e] = in_abs[edge_tab[e][2:0]];
                        nb_next[e] = in_abs[edge_tab[e][5:3]];
                        x_next[e]  = in_mask[edge_tab[e][2:0]] ^ in_mask[edge_tab[e][5:3]];
                    end
                    m1_next = in_mask[0];
                    for (int a = 0; a < 3; a++)
                        tri_next[a] = (in_c[0] != 5'd0) && (in_c[1] != 5'd0)
                                   && (in_c[2] != 5'd0) && (in_mask[0] ^ in_mask[1 << a]);
                    e_next = 4'd0;
                    n_next = 4'd0;
                    for (int a = 0; a < 3; a++)
                        sum_next[a] = 16'd0;
                    avg_ph_next = 1'b0;
                    state_next = S_EDGE;
                end
            end
            S_EDGE:
            begin
                if (e_reg == 4'(NE))
                begin
                    axis_next   = 2'd0;
                    avg_ph_next = 1'b1;
                    state_next  = S_AVG;
                end
                else if (x_reg[0])
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end
                else
                begin
                    for (int e = 0; e < NE - 1; e++)
                    begin
                        na_next[e] = na_reg[e+1];
                        nb_next[e] = nb_reg[e+1];
                        x_next[e]  = x_reg[e+1];
                    end
                    e_next = e_reg + 4'd1;
                end
            end
            S_DIVW:
            begin
                if (div_done)
                begin
                    if (!avg_ph_reg)
                    begin
                        // crossing fraction along the edge, corner offsets elsewhere
                        for (int a = 0; a < 3; a++)
                        begin
                            if (ends[a] != ends[3+a])
                                sum_next[a] = sum_reg[a] + 16'(div_quot);
                            else if (ends[a])
                                sum_next[a] = sum_reg[a] + 16'(snm_pkg::Q12_ONE);
                        end
                        n_next = n_reg + 4'd1;
                        for (int e = 0; e < NE - 1; e++)
                        begin
                            na_next[e] = na_reg[e+1];
                            nb_next[e] = nb_reg[e+1];
                            x_next[e]  = x_reg[e+1];
                        end
                        e_next = e_reg + 4'd1;
                        state_next = S_EDGE;
                    end
                    else
                    begin
                        pos_next[axis_reg] = (pos_sum > 18'(snm_pkg::POS_MAX))
                                           ? 17'(snm_pkg::POS_MAX) : 17'(pos_sum);
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_AVG;
                    end
                end
            end
            S_AVG:
            begin
                if (axis_reg == 2'd3)
                    state_next = S_BASE1;
                else
                begin
                    div_num = snm_pkg::DIV_NUM_W'({sum_reg[axis_reg], 1'b0} + 17'(n_reg));
                    div_dvs = snm_pkg::DIV_DVS_W'({n_reg, 1'b0});
                    div_start  = 1'b1;
                    state_next = S_DIVW;
                end
            end
            S_BASE1:
            begin
                tmp_next   = 10'(cz_reg) * 10'(side) + 10'(cy_reg);
                sq_next    = 11'(side) * 11'(side);
                state_next = S_BASE2;
            end
            S_BASE2:
            begin
                base_next   = RW'(tmp_reg) * RW'(side) + RW'(cx_reg);
                mod_r_next  = RW'(tmp_reg) * RW'(side) + RW'(cx_reg);
                mod_k_next  = 4'(KMAX);
                tri_ph_next = 1'b0;
                state_next  = S_MOD;
            end
            S_MOD:
            begin
                mod_r_next = mod_step;
                if (mod_k_reg == 4'd0)
                    state_next = tri_ph_reg ? S_TREAD : S_VTX;
                else
                    mod_k_next = mod_k_reg - 4'd1;
            end
            S_VTX:
            begin
                if (out_free)
                begin
                    wr_en          = 1'b1;
                    v_next[0]      = vcount_reg;
                    vcount_next    = vcount_reg + 16'd1;
                    out_valid_next = 1'b1;
                    out_kind_next  = snm_pkg::KIND_VERTEX;
                    out_last_next  = (tri_reg == 3'd0);
                    out_data_next  = {PAD_W'(0), vcount_reg, pos_reg[2], pos_reg[1], pos_reg[0]};
                    axis_next      = 2'd0;
                    state_next     = (tri_reg == 3'd0) ? S_IDLE : S_AXIS;
                end
            end
            S_AXIS:
            begin
                if (tri_reg[axis_reg])
                begin
                    j_next     = 2'd1;
                    state_next = S_TADDR;
                end
                else
                    axis_next = axis_reg + 2'd1;
            end
            S_TADDR:
            begin
                mod_r_next  = base_reg - sub;
                mod_k_next  = 4'(KMAX);
                tri_ph_next = 1'b1;
                state_next  = S_MOD;
            end
            S_TREAD:
            begin
                rd_en      = 1'b1;
                state_next = S_TCAP;
            end
            S_TCAP:
            begin
                v_next[j_reg] = rd_data_reg;
                if (j_reg == 2'd3)
                begin
                    step_next  = 3'd0;
                    state_next = S_TEMIT;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_TADDR;
                end
            end
            S_TEMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = snm_pkg::KIND_TRIANGLE;
                    out_last_next  = (step_reg == 3'd5) && (tri_rest == 3'd0);
                    // quad order v0 v1 v2, v2 v1 v3
                    unique case (step_reg)
                        3'd0:        out_data_next = {PAD_W'(0), v_reg[0], 51'd0};
                        3'd1, 3'd4:  out_data_next = {PAD_W'(0), v_reg[1], 51'd0};
                        3'd2, 3'd3:  out_data_next = {PAD_W'(0), v_reg[2], 51'd0};
                        default:     out_data_next = {PAD_W'(0), v_reg[3], 51'd0};
                    endcase
                    if (step_reg == 3'd5)
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = (tri_rest == 3'd0) ? S_IDLE : S_AXIS;
                    end
                    else
                        step_next = step_reg + 3'd1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            grid_res_reg  <= 5'd31;
            vcount_reg    <= 16'd0;
            out_valid_reg <= 1'b0;
            avg_ph_reg    <= 1'b0;
            tri_ph_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            grid_res_reg  <= grid_res_next;
            vcount_reg    <= vcount_next;
            out_valid_reg <= out_valid_next;
            avg_ph_reg    <= avg_ph_next;
            tri_ph_reg    <= tri_ph_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next; cy_reg <= cy_next; cz_reg <= cz_next;
        na_reg <= na_next; nb_reg <= nb_next; x_reg <= x_next;
        e_reg <= e_next; n_reg <= n_next;
        sum_reg <= sum_next; pos_reg <= pos_next;
        axis_reg <= axis_next; tri_reg <= tri_next; m1_reg <= m1_next;
        tmp_reg <= tmp_next; sq_reg <= sq_next; base_reg <= base_next;
        mod_r_reg <= mod_r_next; mod_k_reg <= mod_k_next;
        j_reg <= j_next; step_reg <= step_next; v_reg <= v_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    // vertex map, one port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            map_mem[map_addr] <= vcount_reg;
        if (rd_en)
            rd_data_reg <= map_mem[map_addr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

/* hdl/snm_chk.sv */
// ----------------------------------------------------------------------------
// snm_chk
// Port-level checks of the surface nets mesher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module snm_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata,
    input wire logic        m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // a stalled word stays up and unchanged
    `SNM_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `SNM_ASSERT_NXT(a_out_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `SNM_ASSERT_NXT(a_side_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable({m_axis_tuser, m_axis_tlast}))

    // triangle words carry no position
    `SNM_ASSERT_IMP(a_tri_nopos, clk, rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[50:0] == 51'd0)

    // pad bits stay clear
    `SNM_ASSERT_IMP(a_pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[71:67] == 5'd0)

endmodule

bind surface_nets_cell_mesher_unit snm_chk u_snm_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* sim/surface_nets_cell_mesher_unit_test.sv */
// ----------------------------------------------------------------------------
// surface_nets_cell_mesher_unit_test
// Streams grid cells into the mesher and checks every vertex and triangle
// index word against a predictor that tracks the vertex map and counter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module surface_nets_cell_mesher_unit_test;

    localparam int MAP_WORDS   = 32768;
    localparam int STALL_LIMIT = 6000;
    localparam int SETTLE_CYC  = 400;
    localparam int HOLD_CYC    = 1500;

    typedef struct packed {
        logic        kind;
        logic [16:0] px;
        logic [16:0] py;
        logic [16:0] pz;
        logic [15:0] idx;
        logic        last;
    } mesh_word_t;

    typedef logic signed [15:0] corner_set_t [8];

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [4:0] cfg_wdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [snm_pkg::IN_DATA_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [snm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;

    // predictor state
    logic [15:0] vertex_map [MAP_WORDS];
    bit          map_written [MAP_WORDS];
    logic [15:0] next_vertex;
    int          side_len;
    mesh_word_t  pending_words [$];

    int edge_lo [12] = '{0, 2, 4, 6, 0, 1, 4, 5, 0, 1, 2, 3};
    int edge_hi [12] = '{1, 3, 5, 7, 2, 3, 6, 7, 4, 5, 6, 7};

    int mismatches = 0;
    int cells_sent = 0;
    int vertex_words = 0;
    int index_words = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    bit hold_request = 0;

    surface_nets_cell_mesher_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int wrap_map(input longint a);
        return int'(((a % MAP_WORDS) + MAP_WORDS) % MAP_WORDS);
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[15:0];
    endfunction

    function automatic logic [7:0] sign_mask(input corner_set_t d);
        logic [7:0] m;
        for (int i = 0; i < 8; i++)
            m[i] = (d[i] > 0);
        return m;
    endfunction

    // expected words for one accepted cell, map and counter updated
    task automatic mesh_cell(input logic [4:0] cx, input logic [4:0] cy,
                             input logic [4:0] cz, input corner_set_t d);
        logic [7:0] m;
        longint sum [3];
        longint na, nb, den, t, ce, p, base;
        longint stride [5];
        longint s1, s2;
        int n, i0, ea, eb, m1;
        logic [16:0] pos [3];
        logic [15:0] quad [6];
        logic [4:0] c [3];
        mesh_word_t w;
        mesh_word_t words [$];
        m = sign_mask(d);
        if (m == 8'h00 || m == 8'hff)
            return;
        c[0] = cx;
        c[1] = cy;
        c[2] = cz;
        sum = '{0, 0, 0};
        n = 0;
        // crossing fractions on sign-changing edges
        for (int e = 0; e < 12; e++)
        begin
            ea = edge_lo[e];
            eb = edge_hi[e];
            if (m[ea] != m[eb])
            begin
                na = (d[ea] < 0) ? -longint'(d[ea]) : longint'(d[ea]);
                nb = (d[eb] < 0) ? -longint'(d[eb]) : longint'(d[eb]);
                den = na + nb;
                t = (na * 2 * snm_pkg::Q12_ONE + den) / (2 * den);
                for (int a = 0; a < 3; a++)
                begin
                    if (((ea >> a) & 1) != ((eb >> a) & 1))
                        sum[a] += t;
                    else if ((ea >> a) & 1)
                        sum[a] += snm_pkg::Q12_ONE;
                end
                n++;
            end
        end
        // mean position, saturated
        for (int a = 0; a < 3; a++)
        begin
            ce = (sum[a] * 2 + n) / (2 * n);
            p = longint'(c[a]) * snm_pkg::Q12_ONE + ce;
            pos[a] = (p > snm_pkg::POS_MAX) ? 17'(snm_pkg::POS_MAX) : p[16:0];
        end
        base = longint'(cx) + longint'(cy) * side_len + longint'(cz) * side_len * side_len;
        i0 = wrap_map(base);
        vertex_map[i0] = next_vertex;
        map_written[i0] = 1'b1;
        w = '{snm_pkg::KIND_VERTEX, pos[0], pos[1], pos[2], next_vertex, 1'b0};
        words.insert(words.size(), w);
        next_vertex = next_vertex + 16'd1;
        // quads toward lower neighbors
        if (cx != 0 && cy != 0 && cz != 0)
        begin
            stride = '{1, side_len, side_len * side_len, 1, side_len};
            m1 = m[0];
            for (int a = 0; a < 3; a++)
            begin
                if (m[0] != m[1 << a])
                begin
                    s1 = stride[a + 1 + m1];
                    s2 = stride[a + 2 - m1];
                    quad[0] = vertex_map[i0];
                    quad[1] = vertex_map[wrap_map(base - s1)];
                    quad[2] = vertex_map[wrap_map(base - s2)];
                    quad[5] = vertex_map[wrap_map(base - s1 - s2)];
                    quad[3] = quad[2];
                    quad[4] = quad[1];
                    foreach (quad[q])
                    begin
                        w = '{snm_pkg::KIND_TRIANGLE, 17'd0, 17'd0, 17'd0, quad[q], 1'b0};
                        words.insert(words.size(), w);
                    end
                end
            end
        end
        words[words.size() - 1].last = 1'b1;
        pending_words = {pending_words, words};
    endtask

    // keep quads away from neighbors whose map entry was never written
    task automatic avoid_unwritten(input logic [4:0] cx, input logic [4:0] cy,
                                   input logic [4:0] cz, inout corner_set_t d);
        logic [7:0] m;
        longint base, s1, s2;
        longint stride [5];
        int m1;
        if (cx == 0 || cy == 0 || cz == 0)
            return;
        base = longint'(cx) + longint'(cy) * side_len + longint'(cz) * side_len * side_len;
        stride = '{1, side_len, side_len * side_len, 1, side_len};
        for (int a = 0; a < 3; a++)
        begin
            m = sign_mask(d);
            m1 = m[0];
            s1 = stride[a + 1 + m1];
            s2 = stride[a + 2 - m1];
            if (m[0] != m[1 << a] && !(map_written[wrap_map(base - s1)] &&
                map_written[wrap_map(base - s2)] && map_written[wrap_map(base - s1 - s2)]))
                d[1 << a] = d[0];
        end
    endtask

    // send one cell word, bursts with random gaps
    task automatic send_cell(input logic [4:0] cx, input logic [4:0] cy,
                             input logic [4:0] cz, input corner_set_t dens);
        corner_set_t d;
        int gap;
        d = dens;
        avoid_unwritten(cx, cy, cz, d);
        @(negedge clk);
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_axis_tdata <= {1'b0, d[7], d[6], d[5], d[4], d[3], d[2], d[1], d[0], cz, cy, cx};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        cells_sent++;
        mesh_cell(cx, cy, cz, d);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_words.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_grid_res(input logic [4:0] res);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= res;
        @(negedge clk);
        cfg_we <= 1'b0;
        side_len = int'(res) + 1;
    endtask

    // raster sweep of an n^3 box over a random plane field
    task automatic sweep_box(input int n, input int hold_at, input int pause_at);
        longint gx, gy, gz, off, v;
        corner_set_t d;
        int count;
        gx = longint'($urandom_range(0, 6000)) - 3000;
        gy = longint'($urandom_range(0, 6000)) - 3000;
        gz = longint'($urandom_range(0, 6000)) - 3000;
        off = -((gx + gy + gz) * n) / 2 + longint'($urandom_range(0, 2000)) - 1000;
        count = 0;
        for (int z = 0; z < n; z++)
            for (int y = 0; y < n; y++)
                for (int x = 0; x < n; x++)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        v = gx * (x + (i & 1)) + gy * (y + ((i >> 1) & 1))
                            + gz * (z + ((i >> 2) & 1)) + off;
                        if ($urandom_range(0, 15) == 0)
                            v += longint'($urandom_range(0, 800)) - 400;
                        d[i] = clamp16(v);
                    end
                    if (count == hold_at)
                        hold_request = 1'b1;
                    if (count == pause_at)
                        wait_drained();
                    send_cell(5'(x), 5'(y), 5'(z), d);
                    count++;
                end
    endtask

    task automatic test_directed_cells();
        corner_set_t d;
        d = '{default: 16'sd32767};
        send_cell(5'd0, 5'd0, 5'd0, d);
        d = '{default: -16'sd32768};
        send_cell(5'd3, 5'd4, 5'd5, d);
        d = '{default: 16'sd0};
        send_cell(5'd1, 5'd1, 5'd1, d);
        d = '{16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768,
              -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
        send_cell(5'd0, 5'd0, 5'd0, d);
        d = '{-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767,
              16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
        send_cell(5'd30, 5'd0, 5'd30, d);
        // crossings pinned at the far x face, position saturates past the grid
        d = '{16'sd4096, 16'sd0, 16'sd4096, 16'sd0, 16'sd4096, 16'sd0, 16'sd4096, 16'sd0};
        send_cell(5'd31, 5'd0, 5'd0, d);
        // single positive far corner, zeros elsewhere
        d = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1};
        send_cell(5'd30, 5'd30, 5'd30, d);
        d = '{16'sd1200, -16'sd5, 16'sd77, -16'sd30000, 16'sd2, -16'sd1, 16'sd9000, -16'sd400};
        send_cell(5'd0, 5'd5, 5'd9, d);
        // small box so quads on every axis see written neighbors
        sweep_box(2, -1, -1);
        sweep_box(2, -1, -1);
    endtask

    task automatic test_smallest_grid();
        write_grid_res(5'd1);
        repeat (4)
            sweep_box(1, -1, -1);
        sweep_box(2, -1, -1);
    endtask

    task automatic test_backpressure();
        write_grid_res(5'd4);
        sweep_box(4, 10, -1);
        sweep_box(4, -1, -1);
    endtask

    task automatic test_mid_pause();
        write_grid_res(5'd5);
        sweep_box(5, -1, 60);
    endtask

    task automatic test_random_cells();
        corner_set_t d;
        write_grid_res(5'd31);
        sweep_box(4, -1, -1);
        repeat (100)
        begin
            for (int i = 0; i < 8; i++)
            begin
                case ($urandom_range(0, 5))
                    0: d[i] = 16'sd32767;
                    1: d[i] = -16'sd32768;
                    2: d[i] = 16'sd0;
                    default: d[i] = 16'($urandom_range(0, 65535));
                endcase
            end
            send_cell(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                      5'($urandom_range(0, 31)), d);
        end
    endtask

    // receiver stall patterns and the long hold-off
    initial
    begin
        int seg;
        int mode;
        m_axis_tready = 1'b0;
        forever
        begin
            seg = $urandom_range(10, 60);
            mode = $urandom_range(0, 2);
            repeat (seg)
            begin
                @(negedge clk);
                if (hold_request)
                begin
                    hold_request = 1'b0;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYC) @(negedge clk);
                end
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result checking
    always @(posedge clk)
    begin
        mesh_word_t w;
        mesh_word_t g;
        if (m_axis_tvalid && m_axis_tready)
        begin
            g = '{m_axis_tuser, m_axis_tdata[16:0], m_axis_tdata[33:17],
                  m_axis_tdata[50:34], m_axis_tdata[66:51], m_axis_tlast};
            if (g.kind == snm_pkg::KIND_VERTEX)
                vertex_words++;
            else
                index_words++;
            if (pending_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: kind %0d pos %0d %0d %0d idx %0d last %0d",
                             g.kind, g.px, g.py, g.pz, g.idx, g.last);
            end
            else
            begin
                w = pending_words.pop_front();
                if (g !== w)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp kind %0d pos %0d %0d %0d idx %0d last %0d,",
                                 w.kind, w.px, w.py, w.pz, w.idx, w.last,
                                 " got kind %0d pos %0d %0d %0d idx %0d last %0d",
                                 g.kind, g.px, g.py, g.pz, g.idx, g.last);
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 5'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        next_vertex = 16'd0;
        side_len = 32;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cells();
        wait_drained();
        test_smallest_grid();
        wait_drained();
        test_backpressure();
        wait_drained();
        test_mid_pause();
        wait_drained();
        test_random_cells();
        wait_drained();

        if (pending_words.size() != 0)
            mismatches++;
        $display("covered %0d cells, %0d vertex words, %0d index words", cells_sent,
                 vertex_words, index_words);
        $display("grid sizes 1, 4, 5 and 31, long receiver hold-off, drain pauses, %0d errors",
                 mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/snm_pkg.sv
hdl/snm_div.sv
hdl/surface_nets_cell_mesher_unit.sv
hdl/snm_chk.sv
sim/surface_nets_cell_mesher_unit_test.sv
